FILE: hw/rtl/quad_pulse_counter_period_assert.svh
// Assertion macros for the pulse counter
`ifndef QUAD_PULSE_COUNTER_PERIOD_ASSERT_SVH
`define QUAD_PULSE_COUNTER_PERIOD_ASSERT_SVH

// hold cons in the same cycle as ante
`define QPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// hold cons in the cycle after ante
`define QPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

FILE: hw/rtl/qpc_pkg.sv
`timescale 1ns / 1ps

package qpc_pkg;

    localparam int CHANNELS     = 4;
    localparam int CH_W         = 2;
    localparam int PIN_W        = 4;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 32;
    localparam int PERIOD_OUT_W = 20;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 56;

    localparam logic [TIME_W-1:0] PERIOD_MAX = TIME_W'(999999);

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_READ   = 1'b1
    } t_mode;

endpackage

FILE: hw/rtl/quad_pulse_counter_period.sv
`timescale 1ns / 1ps
// Four-channel falling-edge pulse counter with period measurement.
// Input stream (s_axis): tuser carries the mode. Mode sample gives the four
// pin levels and the millisecond time; every channel takes its new level, and
// a falling edge bumps the channel count and stores the edge interval.
// Mode read names a channel; the block returns its count and clears it, and
// returns the period raised to the idle time and saturated at 999999.
// Output stream (m_axis): one transaction per read, none per sample.
// Flow: a read is accepted into the input register, processed once the output
// register is free, and its result is then registered in the output register.
// Throughput: one transaction per cycle unless a read is held; per-channel
// compare, increment and subtract lie between input and state/result registers.
// Reset: synchronous, active low; clears all counts, periods, edge times and
// prior levels, and drops both valid flags.
// Stall: a waiting result holds in the output register; samples keep flowing,
// and a read waits in the input register, holding s_axis_tready low, until
// the result is taken.
`include "quad_pulse_counter_period_assert.svh"

module quad_pulse_counter_period (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pin_levels[3:0], now_ms[35:4], channel[37:36], zero pad[39:38]
    input  logic [qpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // mode[0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pulse_count[31:0], pulse_period_ms[51:32], zero pad[55:52]
    output logic [qpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic                                r_in_valid;
    qpc_pkg::t_mode                      r_in_mode;
    logic [qpc_pkg::PIN_W-1:0]           r_in_pins;
    logic [qpc_pkg::TIME_W-1:0]          r_in_now;
    logic [qpc_pkg::CH_W-1:0]            r_in_ch;

    logic [qpc_pkg::COUNT_W-1:0]         r_edge_count [qpc_pkg::CHANNELS];
    logic [qpc_pkg::TIME_W-1:0]          r_period     [qpc_pkg::CHANNELS];
    logic [qpc_pkg::TIME_W-1:0]          r_last_edge  [qpc_pkg::CHANNELS];
    logic [qpc_pkg::CHANNELS-1:0]        r_prior_level;

    logic [qpc_pkg::COUNT_W-1:0]         n_edge_count [qpc_pkg::CHANNELS];
    logic [qpc_pkg::TIME_W-1:0]          n_period     [qpc_pkg::CHANNELS];
    logic [qpc_pkg::TIME_W-1:0]          n_last_edge  [qpc_pkg::CHANNELS];
    logic [qpc_pkg::CHANNELS-1:0]        n_prior_level;

    logic                                r_out_valid;
    logic [qpc_pkg::COUNT_W-1:0]         r_out_count;
    logic [qpc_pkg::PERIOD_OUT_W-1:0]    r_out_period;

    logic                                w_out_free;
    logic                                w_fire;
    logic                                w_accept;
    logic                                w_read;
    logic [qpc_pkg::TIME_W-1:0]          w_idle;
    logic [qpc_pkg::TIME_W-1:0]          w_raised;
    logic [qpc_pkg::TIME_W-1:0]          w_sat;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && (r_in_mode == qpc_pkg::MODE_SAMPLE || w_out_free);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_read        = w_fire && (r_in_mode == qpc_pkg::MODE_READ);

    assign w_idle   = r_in_now - r_last_edge[r_in_ch];
    assign w_raised = (w_idle > r_period[r_in_ch]) ? w_idle : r_period[r_in_ch];
    assign w_sat    = (w_raised > qpc_pkg::PERIOD_MAX) ? qpc_pkg::PERIOD_MAX : w_raised;

    always_comb begin
        n_edge_count  = r_edge_count;
        n_period      = r_period;
        n_last_edge   = r_last_edge;
        n_prior_level = r_prior_level;
        if (w_fire && r_in_mode == qpc_pkg::MODE_SAMPLE) begin
            for (int i = 0; i < qpc_pkg::CHANNELS; i++) begin
                if (!r_in_pins[i] && r_prior_level[i]) begin
                    n_edge_count[i] = r_edge_count[i] + 1'b1;
                    n_period[i]     = r_in_now - r_last_edge[i];
                    n_last_edge[i]  = r_in_now;
                end
                n_prior_level[i] = r_in_pins[i];
            end
        end else if (w_read) begin
            n_edge_count[r_in_ch] = '0;
            n_period[r_in_ch]     = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_mode <= qpc_pkg::t_mode'(s_axis_tuser[0]);
            r_in_pins <= s_axis_tdata[3:0];
            r_in_now  <= s_axis_tdata[35:4];
            r_in_ch   <= s_axis_tdata[37:36];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < qpc_pkg::CHANNELS; i++) begin
                r_edge_count[i] <= '0;
                r_period[i]     <= '0;
                r_last_edge[i]  <= '0;
            end
            r_prior_level <= '0;
        end else begin
            r_edge_count  <= n_edge_count;
            r_period      <= n_period;
            r_last_edge   <= n_last_edge;
            r_prior_level <= n_prior_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_read) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_out_count  <= r_edge_count[r_in_ch];
            r_out_period <= w_sat[qpc_pkg::PERIOD_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        (qpc_pkg::OUT_TDATA_W - qpc_pkg::COUNT_W - qpc_pkg::PERIOD_OUT_W)'(0),
        r_out_period,
        r_out_count
    };

    `QPC_ASSERT_NEXT(a_read_loads_result, w_read, r_out_valid)
    `QPC_ASSERT_NEXT(a_sample_no_result,
        w_fire && r_in_mode == qpc_pkg::MODE_SAMPLE && w_out_free, !r_out_valid)
    `QPC_ASSERT_NEXT(a_levels_follow_sample,
        w_fire && r_in_mode == qpc_pkg::MODE_SAMPLE, r_prior_level == $past(r_in_pins))
    `QPC_ASSERT_NOW(a_period_saturated, r_out_valid,
        {12'd0, r_out_period} <= qpc_pkg::PERIOD_MAX)

endmodule

FILE: verif/tb_quad_pulse_counter_period.sv
`timescale 1ns / 1ps

module tb_quad_pulse_counter_period;
    import qpc_pkg::*;

    localparam int LONG_STALL  = 250;
    localparam int PHASE_ITEMS = 600;
    localparam int ROWS        = 21;

    typedef struct packed {
        logic [COUNT_W-1:0]      count;
        logic [PERIOD_OUT_W-1:0] period;
    } t_readout;

    typedef struct packed {
        t_mode             mode;
        logic [PIN_W-1:0]  pins;
        logic [TIME_W-1:0] now;
        logic [CH_W-1:0]   ch;
        logic              typed;
        t_readout          want;
    } t_stim_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [COUNT_W-1:0] model_count  [CHANNELS];
    logic [TIME_W-1:0]  model_period [CHANNELS];
    logic [TIME_W-1:0]  model_edge_t [CHANNELS];
    logic               model_level  [CHANNELS];
    t_readout           readouts_due [$];
    t_readout           head;
    int                 fail_count   = 0;
    int                 send_gap_pct = 0;
    int                 take_gap_pct = 0;
    bit                 stall_request = 1'b0;
    int                 stall_left   = 0;
    logic [TIME_W-1:0]  clock_ms     = '0;

    t_stim_row directed_rows [ROWS] = '{
        '{MODE_READ,   4'h0, 32'h0000_0000, 2'd0, 1'b1, '{32'd0, 20'd0}},
        '{MODE_READ,   4'hf, 32'h0000_0005, 2'd3, 1'b1, '{32'd0, 20'd5}},
        '{MODE_SAMPLE, 4'h0, 32'h0000_0006, 2'd0, 1'b0, '0},
        '{MODE_SAMPLE, 4'hf, 32'h0000_000a, 2'd3, 1'b0, '0},
        '{MODE_SAMPLE, 4'h0, 32'h0000_0014, 2'd0, 1'b0, '0},
        '{MODE_READ,   4'h0, 32'h0000_0019, 2'd1, 1'b1, '{32'd1, 20'd20}},
        '{MODE_READ,   4'h0, 32'h0000_001e, 2'd1, 1'b0, '0},
        '{MODE_SAMPLE, 4'h5, 32'h0000_0064, 2'd0, 1'b0, '0},
        '{MODE_SAMPLE, 4'ha, 32'h0000_1000, 2'd2, 1'b0, '0},
        '{MODE_READ,   4'h0, 32'hffff_ffff, 2'd2, 1'b1, '{32'd2, 20'd999999}},
        '{MODE_SAMPLE, 4'hf, 32'hffff_fff0, 2'd0, 1'b0, '0},
        '{MODE_SAMPLE, 4'h0, 32'h0000_0010, 2'd1, 1'b0, '0},
        '{MODE_READ,   4'h0, 32'h0000_0011, 2'd1, 1'b1, '{32'd1, 20'd999999}},
        '{MODE_SAMPLE, 4'h8, 32'h0000_0020, 2'd0, 1'b0, '0},
        '{MODE_SAMPLE, 4'h0, 32'h0000_0010 + 32'd999999, 2'd0, 1'b0, '0},
        '{MODE_READ,   4'h0, 32'h0000_0010 + 32'd1000000, 2'd3, 1'b1, '{32'd3, 20'd999999}},
        '{MODE_SAMPLE, 4'h1, 32'h0000_0020, 2'd0, 1'b0, '0},
        '{MODE_SAMPLE, 4'h0, 32'h0000_0010 + 32'd1000000, 2'd0, 1'b0, '0},
        '{MODE_READ,   4'h0, 32'h0000_0010 + 32'd1000000, 2'd0, 1'b1, '{32'd4, 20'd999999}},
        '{MODE_READ,   4'h0, 32'h0000_0010 + 32'd1000000, 2'd0, 1'b1, '{32'd0, 20'd999999}},
        '{MODE_READ,   4'h0, 32'h0000_0010 + 32'd1000050, 2'd3, 1'b0, '0}
    };

    quad_pulse_counter_period DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic void clear_counters();
        for (int c = 0; c < CHANNELS; c++) begin
            model_count[c]  = '0;
            model_period[c] = '0;
            model_edge_t[c] = '0;
            model_level[c]  = 1'b0;
        end
    endfunction

    function automatic bit count_pulses(input t_mode mode, input logic [PIN_W-1:0] pins,
                                        input logic [TIME_W-1:0] now,
                                        input logic [CH_W-1:0] ch, output t_readout ro);
        logic [TIME_W-1:0] idle;
        ro = '0;
        if (mode == MODE_SAMPLE) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (!pins[c]) begin
                    if (model_level[c]) begin
                        model_count[c]  = model_count[c] + 1'b1;
                        model_period[c] = now - model_edge_t[c];
                        model_edge_t[c] = now;
                    end
                    model_level[c] = 1'b0;
                end else begin
                    model_level[c] = 1'b1;
                end
            end
            return 1'b0;
        end
        if (int'(ch) >= CHANNELS)
            return 1'b1;
        ro.count = model_count[ch];
        model_count[ch] = '0;
        idle = now - model_edge_t[ch];
        if (idle > model_period[ch])
            model_period[ch] = idle;
        if (model_period[ch] > PERIOD_MAX)
            model_period[ch] = PERIOD_MAX;
        ro.period = model_period[ch][PERIOD_OUT_W-1:0];
        return 1'b1;
    endfunction

    task automatic offer_item(input t_mode mode, input logic [PIN_W-1:0] pins,
                              input logic [TIME_W-1:0] now, input logic [CH_W-1:0] ch,
                              input logic typed, input t_readout want);
        t_readout ro;
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, ch, now, pins};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (count_pulses(mode, pins, now, ch, ro))
            readouts_due.push_back(typed ? want : ro);
        @(negedge i_clk);
    endtask

    task automatic offer_random(input int read_pct);
        int    pick;
        t_mode mode;
        pick = $urandom_range(99);
        if (pick < 75)
            clock_ms = clock_ms + $urandom_range(2000);
        else if (pick < 88)
            clock_ms = clock_ms + $urandom_range(2000000);
        else if (pick < 95)
            clock_ms = clock_ms + $urandom_range(999998, 1000001);
        else
            clock_ms = $urandom;
        mode = ($urandom_range(99) < read_pct) ? MODE_READ : MODE_SAMPLE;
        offer_item(mode, PIN_W'($urandom), clock_ms, CH_W'($urandom), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (readouts_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                head = readouts_due.pop_front();
                if (m_axis_tdata[COUNT_W-1:0] !== head.count) begin
                    $display("%0t: pulse_count expected %0d, actual %0d",
                             $time, head.count, m_axis_tdata[COUNT_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[COUNT_W +: PERIOD_OUT_W] !== head.period) begin
                    $display("%0t: pulse_period_ms expected %0d, actual %0d",
                             $time, head.period, m_axis_tdata[COUNT_W +: PERIOD_OUT_W]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left    = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
            end
        end
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        clear_counters();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_gap_pct = 12;
        take_gap_pct = 56;
        foreach (directed_rows[i])
            offer_item(directed_rows[i].mode, directed_rows[i].pins, directed_rows[i].now,
                       directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct = (phase == 0) ? 12 : (phase == 1) ? 56 : 0;
            take_gap_pct = (phase == 0) ? 56 : (phase == 1) ? 12 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 0 && k == 300)
                    stall_request = 1'b1;
                if (phase == 0 && k == 340) begin
                    s_axis_tvalid <= 1'b0;
                    while (readouts_due.size() != 0)
                        @(posedge i_clk);
                    @(negedge i_clk);
                end
                offer_random((phase == 0 && k >= 300 && k < 340) ? 70 : 25);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (readouts_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
